### hw/rtl/htps_pkg.sv
// Shared types, slot layout, codes and mate score helper for the probe store.
package htps_pkg;

    // Field and slot widths
    localparam int HASH_W    = 64;
    localparam int DATA_W    = 50;
    localparam int WORD_W    = 1 + HASH_W + DATA_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 15;

    // Data word layout
    localparam int MOVE_LSB  = 0;
    localparam int SCORE_LSB = 16;
    localparam int DEPTH_LSB = 32;
    localparam int GEN_LSB   = 40;
    localparam int BOUND_LSB = 48;

    // Request codes
    localparam logic REQ_PROBE = 1'b0;
    localparam logic REQ_STORE = 1'b1;

    // Bound type codes
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_GENERATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATE_BOUND        = 1'd1;
    localparam logic [14:0]          MATE_BOUND_RESET      = 15'd31000;

    typedef struct packed {
        logic [7:0]  generation;
        logic [14:0] mate_bound;
    } t_cfg;

    // Classified request as it travels from front to back
    typedef struct packed {
        logic               is_store;
        logic [HASH_W-1:0]  hash;
        logic signed [7:0]  depth;
        logic [6:0]         ply;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [DATA_W-1:0]  new_data;
    } t_cmd;

    typedef struct packed {
        logic               matched;
        logic               usable;
        logic signed [15:0] result_score;
        logic               move_valid;
        logic [15:0]        result_move;
        logic               written;
        logic               collision;
    } t_result;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EVAL
    } t_back_state;

    // Shift a mate score by ply and saturate to 16 bits.
    // to_root = 0 moves it away from the root (store), 1 back (probe).
    function automatic logic signed [15:0] mate_adjust(
        input logic signed [15:0] score,
        input logic [6:0]         ply,
        input logic [14:0]        bound,
        input logic               to_root
    );
        logic signed [17:0] s;
        logic signed [17:0] mb;
        logic signed [17:0] p;
        logic signed [17:0] r;
        s  = 18'(score);
        mb = signed'({3'b000, bound});
        p  = signed'({11'b0, ply});
        if (s >= mb) begin
            r = to_root ? s - p : s + p;
        end else if (s <= -mb) begin
            r = to_root ? s + p : s - p;
        end else begin
            r = s;
        end
        if (r > 18'sd32767) begin
            return 16'sh7FFF;
        end else if (r < -18'sd32768) begin
            return 16'sh8000;
        end else begin
            return r[15:0];
        end
    endfunction

endpackage

### hw/rtl/htps_ram.sv
// Generic single write port, single read port RAM with registered read.
module htps_ram #(
    parameter int P_WIDTH     = 8,
    parameter int P_ADDR_BITS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [P_ADDR_BITS-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]     i_wdata,
    input  logic [P_ADDR_BITS-1:0] i_raddr,
    output logic [P_WIDTH-1:0]     o_rdata
);
    localparam int DEPTH = 1 << P_ADDR_BITS;

    logic [P_WIDTH-1:0] r_mem [DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/htps_front.sv
// Front end: accepts request beats, prepares the store data word, queues commands.
module htps_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_hold,
    input  htps_pkg::t_cfg               i_cfg,
    input  logic                         i_push,
    input  logic                         i_req_type,
    input  logic [htps_pkg::HASH_W-1:0]  i_hash,
    input  logic signed [7:0]            i_depth,
    input  logic [6:0]                   i_ply,
    input  logic signed [15:0]           i_alpha,
    input  logic signed [15:0]           i_beta,
    input  logic signed [15:0]           i_score,
    input  logic [15:0]                  i_best_move,
    input  logic [1:0]                   i_node_type,
    output logic                         o_full,
    output logic                         o_cmd_valid,
    output htps_pkg::t_cmd               o_cmd,
    input  logic                         i_cmd_pop
);
    htps_pkg::t_cmd     r_q [2];
    logic               r_wptr;
    logic               r_rptr;
    logic [1:0]         r_cnt;
    logic               w_accept;
    logic signed [15:0] w_store_score;
    htps_pkg::t_cmd     w_cmd;

    assign o_full   = i_hold || (r_cnt == 2'd2);
    assign w_accept = i_push && !o_full;

    // Shift mate scores away from the root before they are stored
    assign w_store_score = htps_pkg::mate_adjust(i_score, i_ply, i_cfg.mate_bound, 1'b0);

    // Classify the beat and pack the data word a store would write
    always_comb begin
        w_cmd.is_store = (i_req_type == htps_pkg::REQ_STORE);
        w_cmd.hash     = i_hash;
        w_cmd.depth    = i_depth;
        w_cmd.ply      = i_ply;
        w_cmd.alpha    = i_alpha;
        w_cmd.beta     = i_beta;
        w_cmd.new_data = {i_node_type, i_cfg.generation, i_depth, w_store_score, i_best_move};
    end

    // Advance queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_accept) begin
                r_wptr <= ~r_wptr;
            end
            if (i_cmd_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_accept, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Hold command payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];
endmodule

### hw/rtl/htps_back.sv
// Back end: clears the table, reads a slot, evaluates probe or store, writes back.
module htps_back #(
    parameter int INDEX_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htps_pkg::t_cfg    i_cfg,
    input  logic              i_cmd_valid,
    input  htps_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_busy,
    output logic              o_res_empty,
    output htps_pkg::t_result o_res,
    input  logic              i_res_pop
);
    localparam int PAD_W = htps_pkg::HASH_W - htps_pkg::DATA_W;

    htps_pkg::t_back_state           r_state;
    htps_pkg::t_back_state           n_state;
    logic [INDEX_BITS-1:0]           r_clr_idx;
    logic [INDEX_BITS-1:0]           n_clr_idx;

    logic                            w_ram_we;
    logic [INDEX_BITS-1:0]           w_ram_waddr;
    logic [htps_pkg::WORD_W-1:0]     w_ram_wdata;
    logic [htps_pkg::WORD_W-1:0]     w_ram_rdata;
    logic [INDEX_BITS-1:0]           w_index;

    logic                            w_valid;
    logic [htps_pkg::HASH_W-1:0]     w_check;
    logic [htps_pkg::DATA_W-1:0]     w_data;
    logic [htps_pkg::HASH_W-1:0]     w_old_hash;
    logic                            w_same;
    logic signed [7:0]               w_old_depth;
    logic [7:0]                      w_old_gen;
    logic signed [15:0]              w_old_score;
    logic [15:0]                     w_old_move;
    logic [1:0]                      w_bound;
    logic signed [15:0]              w_probe_score;
    logic                            w_bound_ok;
    logic                            w_match;
    logic                            w_replace;
    htps_pkg::t_result               w_res;
    logic                            w_res_push;

    htps_pkg::t_result               r_res_q [2];
    logic                            r_res_wptr;
    logic                            r_res_rptr;
    logic [1:0]                      r_res_cnt;

    assign w_index = i_cmd.hash[INDEX_BITS-1:0];

    htps_ram #(
        .P_WIDTH     (htps_pkg::WORD_W),
        .P_ADDR_BITS (INDEX_BITS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_index),
        .o_rdata (w_ram_rdata)
    );

    // Split the slot word read for the head command
    assign {w_valid, w_check, w_data} = w_ram_rdata;
    assign w_old_hash  = w_check ^ {{PAD_W{1'b0}}, w_data};
    assign w_same      = (w_old_hash == i_cmd.hash);
    assign w_old_move  = w_data[htps_pkg::MOVE_LSB +: 16];
    assign w_old_score = w_data[htps_pkg::SCORE_LSB +: 16];
    assign w_old_depth = w_data[htps_pkg::DEPTH_LSB +: 8];
    assign w_old_gen   = w_data[htps_pkg::GEN_LSB +: 8];
    assign w_bound     = w_data[htps_pkg::BOUND_LSB +: 2];
    assign w_match     = w_valid && w_same && !w_old_depth[7];

    // Shift mate scores back toward the root on the way out
    assign w_probe_score = htps_pkg::mate_adjust(w_old_score, i_cmd.ply,
                                                 i_cfg.mate_bound, 1'b1);

    // Check the bound against the probe window
    always_comb begin
        case (w_bound)
            htps_pkg::BOUND_EXACT: w_bound_ok = 1'b1;
            htps_pkg::BOUND_LOWER: w_bound_ok = (w_probe_score >= i_cmd.beta);
            htps_pkg::BOUND_UPPER: w_bound_ok = (w_probe_score <= i_cmd.alpha);
            default:               w_bound_ok = 1'b0;
        endcase
    end

    // Apply the replacement rules
    always_comb begin
        if (!w_valid) begin
            w_replace = 1'b1;
        end else if (w_same) begin
            w_replace = (i_cmd.depth >= w_old_depth);
        end else if (w_old_gen != i_cfg.generation) begin
            w_replace = 1'b1;
        end else begin
            w_replace = (i_cmd.depth > w_old_depth);
        end
    end

    // Build the result beat
    always_comb begin
        w_res = '0;
        if (!i_cmd.is_store) begin
            w_res.matched     = w_match;
            w_res.result_move = w_match ? w_old_move : 16'd0;
            w_res.move_valid  = w_match && (w_old_move != 16'd0);
            w_res.usable      = w_match && (w_old_depth >= i_cmd.depth) && w_bound_ok;
            w_res.result_score = w_res.usable ? w_probe_score : 16'sd0;
        end else begin
            w_res.written   = w_replace;
            w_res.collision = w_valid && !w_same;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            htps_pkg::BK_CLEAR: begin
                if (r_clr_idx == {INDEX_BITS{1'b1}}) begin
                    n_state = htps_pkg::BK_IDLE;
                end
            end
            htps_pkg::BK_IDLE: begin
                if (i_cmd_valid && (r_res_cnt != 2'd2)) begin
                    n_state = htps_pkg::BK_EVAL;
                end
            end
            htps_pkg::BK_EVAL: begin
                n_state = htps_pkg::BK_IDLE;
            end
            default: begin
                n_state = htps_pkg::BK_CLEAR;
            end
        endcase
    end

    // State outputs: clear sweep writes, evaluation write-back and handoff
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = w_index;
        w_ram_wdata = {1'b1, i_cmd.hash ^ {{PAD_W{1'b0}}, i_cmd.new_data}, i_cmd.new_data};
        o_cmd_pop   = 1'b0;
        w_res_push  = 1'b0;
        o_busy      = 1'b0;
        n_clr_idx   = r_clr_idx;
        case (r_state)
            htps_pkg::BK_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_idx;
                w_ram_wdata = '0;
                o_busy      = 1'b1;
                n_clr_idx   = r_clr_idx + 1'b1;
            end
            htps_pkg::BK_EVAL: begin
                w_ram_we   = i_cmd.is_store && w_replace;
                o_cmd_pop  = 1'b1;
                w_res_push = 1'b1;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= htps_pkg::BK_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    // Advance result queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wptr <= 1'b0;
            r_res_rptr <= 1'b0;
            r_res_cnt  <= 2'd0;
        end else begin
            if (w_res_push) begin
                r_res_wptr <= ~r_res_wptr;
            end
            if (i_res_pop) begin
                r_res_rptr <= ~r_res_rptr;
            end
            case ({w_res_push, i_res_pop})
                2'b10:   r_res_cnt <= r_res_cnt + 2'd1;
                2'b01:   r_res_cnt <= r_res_cnt - 2'd1;
                default: r_res_cnt <= r_res_cnt;
            endcase
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_res_q[r_res_wptr] <= w_res;
        end
    end

    assign o_res_empty = (r_res_cnt == 2'd0);
    assign o_res       = r_res_q[r_res_rptr];
endmodule

### hw/rtl/hash_table_probe_store.sv
// Top level of the direct-mapped probe/store position table.
//
//   channel   direction  handshake              payload
//   request   in         push / full            req_type hash depth ply alpha beta
//                                               score best_move node_type
//   result    out        empty / pop            matched usable result_score move_valid
//                                               result_move written collision
//   config    in         i_cfg_we (no wait)     i_cfg_index, i_cfg_wdata
//
// A request goes through back-end state IDLE, which reads its slot from the table RAM,
// then EVAL, which evaluates and writes back; a new request waits until EVAL is done.
// IDLE holds while the result queue is full; a result enters that queue from EVAL.
// After reset the back end sweeps all 2**INDEX_BITS table slots with full held high.
// Two-entry queues on both sides let request and result sides stall independently.
module hash_table_probe_store #(
    parameter int INDEX_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_req_type,
    input  logic [63:0]                        i_hash,
    input  logic signed [7:0]                  i_depth,
    input  logic [6:0]                         i_ply,
    input  logic signed [15:0]                 i_alpha,
    input  logic signed [15:0]                 i_beta,
    input  logic signed [15:0]                 i_score,
    input  logic [15:0]                        i_best_move,
    input  logic [1:0]                         i_node_type,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_matched,
    output logic                               o_usable,
    output logic signed [15:0]                 o_result_score,
    output logic                               o_move_valid,
    output logic [15:0]                        o_result_move,
    output logic                               o_written,
    output logic                               o_collision,
    input  logic                               i_cfg_we,
    input  logic [htps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [htps_pkg::CFG_DAT_W-1:0]     i_cfg_wdata
);
    htps_pkg::t_cfg    r_cfg;
    logic              w_busy;
    logic              w_cmd_valid;
    htps_pkg::t_cmd    w_cmd;
    logic              w_cmd_pop;
    htps_pkg::t_result w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.generation <= 8'd0;
            r_cfg.mate_bound <= htps_pkg::MATE_BOUND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                htps_pkg::CFG_SEARCH_GENERATION: r_cfg.generation <= i_cfg_wdata[7:0];
                htps_pkg::CFG_MATE_BOUND:        r_cfg.mate_bound <= i_cfg_wdata;
                default:                         r_cfg <= r_cfg;
            endcase
        end
    end

    htps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (w_busy),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_req_type  (i_req_type),
        .i_hash      (i_hash),
        .i_depth     (i_depth),
        .i_ply       (i_ply),
        .i_alpha     (i_alpha),
        .i_beta      (i_beta),
        .i_score     (i_score),
        .i_best_move (i_best_move),
        .i_node_type (i_node_type),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    htps_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_busy      (w_busy),
        .o_res_empty (empty),
        .o_res       (w_res),
        .i_res_pop   (pop && !empty)
    );

    assign o_matched      = w_res.matched;
    assign o_usable       = w_res.usable;
    assign o_result_score = w_res.result_score;
    assign o_move_valid   = w_res.move_valid;
    assign o_result_move  = w_res.result_move;
    assign o_written      = w_res.written;
    assign o_collision    = w_res.collision;
endmodule

### hw/rtl/htps_checker.sv
// Port-level checks for the probe store, bound to the top level.
module htps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic               o_matched,
    input logic               o_usable,
    input logic signed [15:0] o_result_score,
    input logic               o_move_valid,
    input logic [15:0]        o_result_move,
    input logic               o_written,
    input logic               o_collision
);
    // The table sweep holds off requests right after reset
    a_clear_blocks: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("request side open right after reset");

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present right after reset");

    // A usable score or a returned move needs a match
    a_usable_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_usable || o_move_valid) |-> o_matched)
        else $error("usable score or move without match");

    // Store results never carry probe fields
    a_store_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_written || o_collision) |-> !o_matched && o_result_move == 16'd0
            && o_result_score == 16'sd0)
        else $error("store result carries probe fields");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result_score) && $stable(o_result_move))
        else $error("waiting result beat changed");
endmodule

bind hash_table_probe_store htps_checker u_htps_checker (.*);

### sim/probe_store_mirror_pkg.sv
// Request type and table mirror used by the probe store testbench.
package probe_store_mirror_pkg;

    import htps_pkg::*;

    localparam int SLOT_BITS  = 16;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int SHOW_LIMIT = 10;

    // One request beat as the testbench drives it
    typedef struct packed {
        logic               req_type;
        logic [63:0]        hash;
        logic signed [7:0]  depth;
        logic [6:0]         ply;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic signed [15:0] score;
        logic [15:0]        best_move;
        logic [1:0]         node_type;
    } t_probe_req;

    // Shadow copy of the table: works out the outcome of each accepted
    // request and checks the outcomes popped from the block in order.
    class probe_store_mirror;
        bit [63:0]  check_mem [SLOT_COUNT];
        bit [49:0]  data_mem  [SLOT_COUNT];
        bit         taken     [SLOT_COUNT];
        bit [7:0]   generation;
        bit [14:0]  mate_bound;
        t_result    due_results [$];
        int         failures;

        function new();
            generation = 8'd0;
            mate_bound = MATE_BOUND_RESET;
            failures   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [14:0] value);
            case (idx)
                CFG_SEARCH_GENERATION: generation = value[7:0];
                CFG_MATE_BOUND:        mate_bound = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Move a mate score by ply (away from root on store, back on probe), then clamp
        function int shift_mate_score(int s, int ply, bit to_root);
            int mb;
            mb = int'(mate_bound);
            if (s >= mb) begin
                s = to_root ? s - ply : s + ply;
            end else if (s <= -mb) begin
                s = to_root ? s + ply : s - ply;
            end
            if (s > 32767) begin
                s = 32767;
            end else if (s < -32768) begin
                s = -32768;
            end
            return s;
        endfunction

        // Apply one accepted request to the shadow table and queue its outcome
        function void note_request(t_probe_req r);
            t_result            res;
            int                 idx;
            bit [49:0]          d;
            bit [49:0]          nd;
            bit [63:0]          old_key;
            logic signed [7:0]  od8;
            logic signed [15:0] s16;
            int                 old_depth;
            int                 new_depth;
            int                 sc;
            int                 ply;
            int                 lo;
            int                 hi;
            bit                 ok;
            bit                 replace;
            res       = '0;
            idx       = int'(r.hash[SLOT_BITS-1:0]);
            d         = data_mem[idx];
            old_key   = check_mem[idx] ^ {14'b0, d};
            od8       = d[39:32];
            old_depth = od8;
            new_depth = r.depth;
            ply       = int'(r.ply);
            if (r.req_type == REQ_PROBE) begin
                if (taken[idx] && old_key == r.hash && old_depth >= 0) begin
                    res.matched     = 1'b1;
                    res.result_move = d[15:0];
                    res.move_valid  = (d[15:0] != 16'd0);
                    if (old_depth >= new_depth) begin
                        s16 = d[31:16];
                        sc  = shift_mate_score(int'(s16), ply, 1'b1);
                        lo  = r.alpha;
                        hi  = r.beta;
                        case (d[49:48])
                            BOUND_EXACT: ok = 1'b1;
                            BOUND_LOWER: ok = (sc >= hi);
                            BOUND_UPPER: ok = (sc <= lo);
                            default:     ok = 1'b0;
                        endcase
                        if (ok) begin
                            res.usable       = 1'b1;
                            res.result_score = 16'(sc);
                        end
                    end
                end
            end else begin
                sc = shift_mate_score(int'(r.score), ply, 1'b0);
                nd = {r.node_type, generation, r.depth, 16'(sc), r.best_move};
                res.collision = taken[idx] && old_key != r.hash;
                if (!taken[idx]) begin
                    replace = 1'b1;
                end else if (old_key == r.hash) begin
                    replace = (new_depth >= old_depth);
                end else if (d[47:40] != generation) begin
                    replace = 1'b1;
                end else begin
                    replace = (new_depth > old_depth);
                end
                if (replace) begin
                    check_mem[idx] = r.hash ^ {14'b0, nd};
                    data_mem[idx]  = nd;
                    taken[idx]     = 1'b1;
                    res.written    = 1'b1;
                end
            end
            due_results.push_back(res);
        endfunction

        function string describe(t_result t);
            return $sformatf("m=%0d u=%0d score=%0d mv=%0d move=%h w=%0d c=%0d",
                t.matched, t.usable, t.result_score, t.move_valid, t.result_move,
                t.written, t.collision);
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= SHOW_LIMIT) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        // Compare one popped outcome with the oldest expectation
        function void check_outcome(t_result seen);
            t_result want;
            if (due_results.size() == 0) begin
                report({"outcome with nothing outstanding: ", describe(seen)});
                return;
            end
            want = due_results.pop_front();
            if (want.matched !== seen.matched || want.usable !== seen.usable ||
                want.result_score !== seen.result_score ||
                want.move_valid !== seen.move_valid ||
                want.result_move !== seen.result_move ||
                want.written !== seen.written || want.collision !== seen.collision) begin
                report({"expected ", describe(want), " got ", describe(seen)});
            end
        endfunction
    endclass

endpackage

### sim/tb.sv
// Testbench top: drives probe and store beats with random idling and checks every outcome.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import htps_pkg::*;
    import probe_store_mirror_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 216;
    localparam int LONG_HOLD  = 300;
    localparam int POOL_SIZE  = 48;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 pop         = 1'b0;
    logic                 i_req_type  = REQ_PROBE;
    logic [63:0]          i_hash      = '0;
    logic signed [7:0]    i_depth     = '0;
    logic [6:0]           i_ply       = '0;
    logic signed [15:0]   i_alpha     = '0;
    logic signed [15:0]   i_beta      = '0;
    logic signed [15:0]   i_score     = '0;
    logic [15:0]          i_best_move = '0;
    logic [1:0]           i_node_type = BOUND_EXACT;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SEARCH_GENERATION;
    logic [CFG_DAT_W-1:0] i_cfg_wdata = '0;
    logic                 full;
    logic                 empty;
    logic                 o_matched;
    logic                 o_usable;
    logic signed [15:0]   o_result_score;
    logic                 o_move_valid;
    logic [15:0]          o_result_move;
    logic                 o_written;
    logic                 o_collision;

    probe_store_mirror mirror = new();
    logic [63:0]       key_pool [POOL_SIZE];
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    bit                long_hold_req = 1'b0;

    hash_table_probe_store #(
        .INDEX_BITS (SLOT_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_hash         (i_hash),
        .i_depth        (i_depth),
        .i_ply          (i_ply),
        .i_alpha        (i_alpha),
        .i_beta         (i_beta),
        .i_score        (i_score),
        .i_best_move    (i_best_move),
        .i_node_type    (i_node_type),
        .empty          (empty),
        .pop            (pop),
        .o_matched      (o_matched),
        .o_usable       (o_usable),
        .o_result_score (o_result_score),
        .o_move_valid   (o_move_valid),
        .o_result_move  (o_result_move),
        .o_written      (o_written),
        .o_collision    (o_collision),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // Free-running clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one beat, optionally after an idle burst, and hold it until taken
    task automatic send_request(input t_probe_req r);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 14);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_req_type  <= r.req_type;
        i_hash      <= r.hash;
        i_depth     <= r.depth;
        i_ply       <= r.ply;
        i_alpha     <= r.alpha;
        i_beta      <= r.beta;
        i_score     <= r.score;
        i_best_move <= r.best_move;
        i_node_type <= r.node_type;
        do @(posedge i_clk); while (full);
        mirror.note_request(r);
    endtask

    // Drop push and wait until every outcome is back, plus some slack
    task automatic settle();
        push <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write both registers back to back; the block must be idle
    task automatic set_search_config(input logic [7:0] gen, input logic [14:0] bound);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SEARCH_GENERATION;
        i_cfg_wdata <= {7'b0, gen};
        @(posedge i_clk);
        mirror.set_reg(CFG_SEARCH_GENERATION, {7'b0, gen});
        i_cfg_index <= CFG_MATE_BOUND;
        i_cfg_wdata <= bound;
        @(posedge i_clk);
        mirror.set_reg(CFG_MATE_BOUND, bound);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_probe_req make_req(logic kind, logic [63:0] hash, int depth,
                                            int ply, int alpha, int beta, int score,
                                            logic [15:0] move, logic [1:0] bound);
        t_probe_req r;
        r.req_type  = kind;
        r.hash      = hash;
        r.depth     = 8'(depth);
        r.ply       = 7'(ply);
        r.alpha     = 16'(alpha);
        r.beta      = 16'(beta);
        r.score     = 16'(score);
        r.best_move = move;
        r.node_type = bound;
        return r;
    endfunction

    // Score near the mate bounds, small, or anywhere
    function automatic int pick_score(int mb);
        logic signed [15:0] r16;
        int v;
        case ($urandom_range(0, 3))
            0: begin
                r16 = 16'($urandom);
                v   = r16;
            end
            1: v = mb + int'($urandom_range(0, 6)) - 3;
            2: v = -mb + int'($urandom_range(0, 6)) - 3;
            default: v = int'($urandom_range(0, 400)) - 200;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic t_probe_req random_req(int mb);
        t_probe_req r;
        int roll;
        r.req_type = ($urandom_range(0, 99) < 45) ? REQ_STORE : REQ_PROBE;
        if ($urandom_range(0, 9) == 0) begin
            r.hash = {32'($urandom), 32'($urandom)};
        end else begin
            r.hash = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            r.depth = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
        end else if (roll == 1) begin
            r.depth = 8'($urandom);
        end else begin
            r.depth = 8'(int'($urandom_range(0, 12)) - 2);
        end
        r.ply       = 7'($urandom);
        r.alpha     = $urandom_range(0, 1) ? 16'($urandom) : 16'(pick_score(mb));
        r.beta      = $urandom_range(0, 1) ? 16'($urandom) : 16'(pick_score(mb));
        r.score     = 16'(pick_score(mb));
        r.best_move = ($urandom_range(0, 99) < 15) ? 16'd0 : 16'($urandom);
        r.node_type = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        return r;
    endfunction

    // Directed beats under reset configuration (generation 0, mate bound 31000)
    task automatic run_directed();
        logic [63:0] h0;
        logic [63:0] ha;
        logic [63:0] hb;
        logic [63:0] hc;
        logic [63:0] hd;
        logic [63:0] he;
        logic [63:0] hf;
        logic [63:0] hg;
        h0 = 64'h0;
        ha = 64'hA5A5_0000_1234_0001;
        hb = 64'h5A5A_FFFF_0000_0001;
        hc = 64'h0000_0000_0000_0002;
        hd = 64'h8000_0000_0000_0002;
        he = 64'hFFFF_FFFF_FFFF_FFFF;
        hf = 64'h0123_4567_89AB_0004;
        hg = 64'h7654_3210_FEDC_0006;
        // zero hash is an ordinary key: miss, store, usable hit, too shallow
        send_request(make_req(REQ_PROBE, h0, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
        send_request(make_req(REQ_STORE, h0, 5, 0, 0, 0, 100, 16'h1234, BOUND_EXACT));
        send_request(make_req(REQ_PROBE, h0, 5, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
        send_request(make_req(REQ_PROBE, h0, 6, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
        // mate scores saturating at both ends of the range
        send_request(make_req(REQ_STORE, ha, 127, 127, 0, 0, 32767, 16'hFFFF, BOUND_LOWER));
        send_request(make_req(REQ_PROBE, ha, -128, 127, 32767, -32768, 0, 16'h0,
                              BOUND_EXACT));
        send_request(make_req(REQ_STORE, ha, 127, 127, 0, 0, -32768, 16'h0, BOUND_UPPER));
        send_request(make_req(REQ_PROBE, ha, 127, 0, 32767, 32767, 0, 16'h0, BOUND_EXACT));
        // other key on a deep slot of this generation: collision, kept
        send_request(make_req(REQ_STORE, hb, 10, 0, 0, 0, 7, 16'h0042, BOUND_EXACT));
        send_request(make_req(REQ_PROBE, hb, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
        // negative stored depth never matches; same key at equal depth replaces
        send_request(make_req(REQ_STORE, hc, -1, 3, 0, 0, 20, 16'h0001, BOUND_EXACT));
        send_request(make_req(REQ_PROBE, hc, -128, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
        send_request(make_req(REQ_STORE, hc, -1, 3, 0, 0, 21, 16'h0002, BOUND_EXACT));
        send_request(make_req(REQ_STORE, hd, 0, 0, 0, 0, -5, 16'h8000, BOUND_EXACT));
        send_request(make_req(REQ_PROBE, hd, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
        // bound type three with no move: matches, never usable
        send_request(make_req(REQ_STORE, he, 3, 50, 0, 0, -31000, 16'h0, 2'd3));
        send_request(make_req(REQ_PROBE, he, 0, 50, 32767, -32768, 0, 16'h0, BOUND_EXACT));
        // upper bound against alpha, lower bound against beta, at the edge
        send_request(make_req(REQ_STORE, hf, 4, 0, 0, 0, 50, 16'h0A0A, BOUND_UPPER));
        send_request(make_req(REQ_PROBE, hf, 4, 0, 49, 0, 0, 16'h0, BOUND_EXACT));
        send_request(make_req(REQ_PROBE, hf, 4, 0, 50, 0, 0, 16'h0, BOUND_EXACT));
        send_request(make_req(REQ_STORE, hg, 4, 0, 0, 0, 50, 16'h0B0B, BOUND_LOWER));
        send_request(make_req(REQ_PROBE, hg, 4, 0, 0, 51, 0, 16'h0, BOUND_EXACT));
        send_request(make_req(REQ_PROBE, hg, 4, 0, 0, 50, 0, 16'h0, BOUND_EXACT));
    endtask

    // Result side: check each popped beat, then pick the next pop
    initial begin
        t_result seen;
        int      hold;
        hold = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                seen.matched      = o_matched;
                seen.usable       = o_usable;
                seen.result_score = o_result_score;
                seen.move_valid   = o_move_valid;
                seen.result_move  = o_result_move;
                seen.written      = o_written;
                seen.collision    = o_collision;
                mirror.check_outcome(seen);
            end
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (hold == 0 && recv_idle_pct != 0 &&
                         $urandom_range(0, 99) < recv_idle_pct) begin
                hold = $urandom_range(1, 14);
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed beats, then phases of random traffic
    initial begin
        logic [15:0] slot;
        logic [7:0]  gen;
        logic [14:0] bound;
        // keys share slots three ways so hits and collisions are common
        for (int i = 0; i < POOL_SIZE / 3; i++) begin
            slot = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom);
            for (int j = 0; j < 3; j++) begin
                key_pool[i * 3 + j] = {32'($urandom), 16'($urandom), slot};
            end
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        settle();
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin gen = 8'd1;   bound = 15'd0;     end
                1: begin gen = 8'd1;   bound = 15'd32767; end
                2: begin gen = 8'd2;   bound = MATE_BOUND_RESET; end
                3: begin gen = 8'd2;   bound = 15'd100;   end
                4: begin gen = 8'd255; bound = 15'($urandom); end
                5: begin gen = 8'd0;   bound = 15'($urandom); end
                6: begin gen = 8'($urandom); bound = 15'($urandom); end
                default: begin gen = 8'($urandom); bound = MATE_BOUND_RESET; end
            endcase
            set_search_config(gen, bound);
            // vary idling per phase; the last phase runs flat out
            send_idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 10 : 40;
            recv_idle_pct = ((ph + 1) % 3 == 0) ? 0 : ((ph + 1) % 3 == 1) ? 10 : 40;
            if (ph == 2 || ph == 5) begin
                send_idle_pct = 0;
                long_hold_req = 1'b1;
            end
            if (ph == PHASES - 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (PHASE_LEN) send_request(random_req(int'(bound)));
            settle();
        end
        if (mirror.failures == 0 && mirror.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
